// ===== design/emm_pkg.sv =====
// Shared constants for the moving-average / expiring min-max block.
// Used by the datapath modules and by the top level; no dependencies.
package emm_pkg;

   localparam int ALPHA_BITS     = 17;
   localparam int LIMIT_BITS     = 16;
   localparam int AGE_BITS       = 16;
   localparam int AVG_BITS       = 32;
   localparam int COUNT_BITS     = 32;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 17;

   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE   = 17'h10000;
   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 17'h08000;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd4;
   localparam logic [AGE_BITS-1:0]   AGE_MAX     = 16'hFFFF;

   // register indexes on the control port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT = 4'd1;

endpackage

// ===== design/emm_average.sv =====
// Next value of the Q16.16 weighted average for one sample.
// Depends on emm_pkg. Pure combinational: one 18x33 multiply, round, add, clamp.
module emm_average
   import emm_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [AVG_BITS-1:0]    avg_now,
   input  logic        [ALPHA_BITS-1:0]  alpha,
   input  logic                          seen_first,
   output logic signed [AVG_BITS-1:0]    avg_next
);

   localparam int SQ_BITS = SAMPLE_BITS + 16;

   // clamp a wide signed value into the signed 32-bit range
   function automatic logic signed [AVG_BITS-1:0] sat32(input logic signed [63:0] x);
      logic signed [AVG_BITS-1:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -64'sh0000_0000_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = x[AVG_BITS-1:0];
      end
      return r;
   endfunction

   logic signed [SQ_BITS-1:0]  s_wide;
   logic signed [AVG_BITS-1:0] s_q;
   logic        [ALPHA_BITS-1:0] alpha_eff;
   logic signed [32:0] diff;
   logic signed [50:0] prod;
   logic signed [50:0] rounded;
   logic signed [34:0] step;
   logic signed [35:0] sum;

   // sample moved to Q16.16, clamped where it is wider than 16 bits
   assign s_wide = $signed({sample, 16'h0000});
   assign s_q    = sat32(64'(s_wide));

   // weights above one act as one
   assign alpha_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;

   // avg + round(alpha * (s - avg)), ties toward plus infinity
   assign diff    = 33'(s_q) - 33'(avg_now);
   assign prod    = $signed({1'b0, alpha_eff}) * diff;
   assign rounded = prod + 51'sd32768;
   assign step    = rounded[50:16];
   assign sum     = 36'(avg_now) + 36'(step);

   // first sample seeds the average
   assign avg_next = seen_first ? sat32(64'(sum)) : s_q;

endmodule

// ===== design/emm_extremes.sv =====
// Next minimum, maximum and their ages for one sample.
// Depends on emm_pkg. Pure combinational: compares and saturating increments.
module emm_extremes
   import emm_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          seen_first,
   input  logic        [LIMIT_BITS-1:0]  limit,
   input  logic signed [SAMPLE_BITS-1:0] min_now,
   input  logic signed [SAMPLE_BITS-1:0] max_now,
   input  logic        [AGE_BITS-1:0]    min_age_now,
   input  logic        [AGE_BITS-1:0]    max_age_now,
   output logic signed [SAMPLE_BITS-1:0] min_next,
   output logic signed [SAMPLE_BITS-1:0] max_next,
   output logic        [AGE_BITS-1:0]    min_age_next,
   output logic        [AGE_BITS-1:0]    max_age_next
);

   logic signed [SAMPLE_BITS-1:0] min_upd, max_upd;
   logic        [AGE_BITS-1:0]    min_age_upd, max_age_upd;

   always_comb begin
      // new extreme restarts its age
      min_upd     = min_now;
      min_age_upd = min_age_now;
      max_upd     = max_now;
      max_age_upd = max_age_now;
      if (sample > max_now) begin
         max_upd     = sample;
         max_age_upd = '0;
      end
      if (sample < min_now) begin
         min_upd     = sample;
         min_age_upd = '0;
      end
      // expiry, tested on the age after the new-extreme check
      if (min_age_upd == limit) begin
         min_upd     = sample;
         min_age_upd = '0;
      end
      if (max_age_upd == limit) begin
         max_upd     = sample;
         max_age_upd = '0;
      end

      if (!seen_first) begin
         min_next     = sample;
         max_next     = sample;
         min_age_next = AGE_BITS'(1);
         max_age_next = AGE_BITS'(1);
      end else begin
         min_next     = min_upd;
         max_next     = max_upd;
         min_age_next = (min_age_upd == AGE_MAX) ? AGE_MAX : min_age_upd + AGE_BITS'(1);
         max_age_next = (max_age_upd == AGE_MAX) ? AGE_MAX : max_age_upd + AGE_BITS'(1);
      end
   end

endmodule

// ===== design/ewma_with_expiring_min_max.sv =====
// Top level: input register, running state, result register and control registers.
// Depends on emm_pkg, emm_average and emm_extremes.
//
// One sample in, one result out, at one item per clock when the result side
// does not stall. A transfer on req_ lands in an input register; while the
// sample waits there, one multiply-round-add for the average and the min/max
// compares run between that register and the result register, and the running
// state is updated at the same edge as the result register. rsp_valid rises when
// the sample moves from the input register into the result register. The result
// and input registers together let a new sample be taken while a finished result
// still waits. Control registers (alpha, expiry_limit) are written through csr_,
// always ready; the user must write them only while idle, unenforced by the block.
module ewma_with_expiring_min_max
   import emm_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // samples
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   // results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic        [COUNT_BITS-1:0]  rsp_sample_number,
   output logic signed [SAMPLE_BITS-1:0] rsp_value,
   output logic signed [SAMPLE_BITS-1:0] rsp_minimum,
   output logic signed [AVG_BITS-1:0]    rsp_average,
   output logic signed [SAMPLE_BITS-1:0] rsp_maximum,
   // control registers
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   // control registers
   logic [ALPHA_BITS-1:0] alpha_ff, alpha_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;

   // input stage
   logic                          in_valid_ff, in_valid_in;
   logic signed [SAMPLE_BITS-1:0] in_sample_ff, in_sample_in;

   // running state
   logic                          seen_ff, seen_in;
   logic signed [AVG_BITS-1:0]    avg_ff, avg_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in, max_ff, max_in;
   logic        [AGE_BITS-1:0]    min_age_ff, min_age_in, max_age_ff, max_age_in;
   logic        [COUNT_BITS-1:0]  count_ff, count_in;

   // result stage
   logic                          rsp_valid_ff, rsp_valid_in;
   logic        [COUNT_BITS-1:0]  rsp_number_ff, rsp_number_in;
   logic signed [SAMPLE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic signed [SAMPLE_BITS-1:0] rsp_min_ff, rsp_min_in, rsp_max_ff, rsp_max_in;
   logic signed [AVG_BITS-1:0]    rsp_avg_ff, rsp_avg_in;

   logic req_take, advance;

   // datapath results for the sample in the input register
   logic signed [AVG_BITS-1:0]    avg_calc;
   logic signed [SAMPLE_BITS-1:0] min_calc, max_calc;
   logic        [AGE_BITS-1:0]    min_age_calc, max_age_calc;

   emm_average #(.SAMPLE_BITS(SAMPLE_BITS)) u_average (
      .sample     (in_sample_ff),
      .avg_now    (avg_ff),
      .alpha      (alpha_ff),
      .seen_first (seen_ff),
      .avg_next   (avg_calc)
   );

   emm_extremes #(.SAMPLE_BITS(SAMPLE_BITS)) u_extremes (
      .sample       (in_sample_ff),
      .seen_first   (seen_ff),
      .limit        (limit_ff),
      .min_now      (min_ff),
      .max_now      (max_ff),
      .min_age_now  (min_age_ff),
      .max_age_now  (max_age_ff),
      .min_next     (min_calc),
      .max_next     (max_calc),
      .min_age_next (min_age_calc),
      .max_age_next (max_age_calc)
   );

   // handshake: the input stage moves on when the result register is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // control register writes; unknown indexes are dropped
   always_comb begin
      alpha_in = alpha_ff;
      limit_in = limit_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ALPHA: alpha_in = csr_data;
            CSR_LIMIT: limit_in = csr_data[LIMIT_BITS-1:0];
            default:   ;
         endcase
      end
   end

   // input stage next values
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_sample_in = in_sample_ff;
      if (req_take) begin
         in_valid_in  = 1'b1;
         in_sample_in = req_sample;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // state and result updates on each transfer into the result register
   always_comb begin
      seen_in       = seen_ff;
      avg_in        = avg_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      min_age_in    = min_age_ff;
      max_age_in    = max_age_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_number_in = rsp_number_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_avg_in    = rsp_avg_ff;
      if (advance) begin
         seen_in       = 1'b1;
         avg_in        = avg_calc;
         min_in        = min_calc;
         max_in        = max_calc;
         min_age_in    = min_age_calc;
         max_age_in    = max_age_calc;
         count_in      = count_ff + COUNT_BITS'(1);
         rsp_valid_in  = 1'b1;
         rsp_number_in = count_ff + COUNT_BITS'(1);
         rsp_value_in  = in_sample_ff;
         rsp_min_in    = min_calc;
         rsp_max_in    = max_calc;
         rsp_avg_in    = avg_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ALPHA_RESET;
         limit_ff     <= LIMIT_RESET;
         in_valid_ff  <= 1'b0;
         seen_ff      <= 1'b0;
         avg_ff       <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         min_age_ff   <= '0;
         max_age_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alpha_ff     <= alpha_in;
         limit_ff     <= limit_in;
         in_valid_ff  <= in_valid_in;
         seen_ff      <= seen_in;
         avg_ff       <= avg_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         min_age_ff   <= min_age_in;
         max_age_ff   <= max_age_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload, no reset
      in_sample_ff  <= in_sample_in;
      rsp_number_ff <= rsp_number_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_avg_ff    <= rsp_avg_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_number = rsp_number_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_minimum       = rsp_min_ff;
   assign rsp_maximum       = rsp_max_ff;
   assign rsp_average       = rsp_avg_ff;

   // each new result carries the next sample number
   a_number_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_sample_number == $past(count_ff) + COUNT_BITS'(1)))
      else $error("sample number did not step by one");

   // the sample always lies between the tracked extremes
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_minimum <= rsp_value && rsp_value <= rsp_maximum))
      else $error("sample outside tracked minimum and maximum");

   // stall is raised only with a full input stage behind a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("input stalled with room to spare");

   // after any transfer the first-sample flag stays set
   a_seen: assert property (@(posedge clock) disable iff (reset)
      advance |=> seen_ff)
      else $error("first-sample flag not set after a transfer");

endmodule

// ===== tb/ewma_with_expiring_min_max_tb.sv =====
// Self-checking testbench for ewma_with_expiring_min_max: drives samples and CSR writes,
// predicts each result in a scoreboard class and checks every result transfer field by field.
// Depends on emm_pkg and the ewma_with_expiring_min_max RTL.
module ewma_with_expiring_min_max_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import emm_pkg::*;

   localparam int SAMPLE_BITS = 16;
   localparam int CYCLE_LIMIT = 500000;
   localparam int IDLE_PHASES = 6;
   localparam int PHASE_ITEMS = 90;
   localparam int TAIL_ITEMS  = 60;
   localparam int PIN_RUN     = 30;   // samples with the extremes pinned and expiry off

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam sample_type ALT_ONES   = {(SAMPLE_BITS/2){2'b01}};
   localparam longint     AVG_HIGH   = 64'sd2147483647;
   localparam longint     AVG_LOW    = -64'sd2147483648;

   typedef struct {
      logic [COUNT_BITS-1:0]      sample_number;
      sample_type                 value;
      sample_type                 minimum;
      logic signed [AVG_BITS-1:0] average;
      sample_type                 maximum;
   } stats_type;

   // Scoreboard: own copy of the running statistics and registers, plus the
   // queue of results still owed by the block
   class ewma_stats_board;
      stats_type             expected_stats[$];
      int                    errors;
      logic [ALPHA_BITS-1:0] alpha;
      logic [LIMIT_BITS-1:0] limit;
      bit                    seeded;
      longint                avg;
      longint                lowest;
      longint                highest;
      logic [AGE_BITS-1:0]   low_age;
      logic [AGE_BITS-1:0]   high_age;
      logic [COUNT_BITS-1:0] count;

      function new();
         errors   = 0;
         alpha    = ALPHA_RESET;
         limit    = LIMIT_RESET;
         seeded   = 1'b0;
         avg      = 0;
         lowest   = 0;
         highest  = 0;
         low_age  = '0;
         high_age = '0;
         count    = '0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] data);
         if (index == CSR_ALPHA)
            alpha = data[ALPHA_BITS-1:0];
         else if (index == CSR_LIMIT)
            limit = data[LIMIT_BITS-1:0];
      endfunction

      function longint clamp32(longint x);
         if (x > AVG_HIGH)
            return AVG_HIGH;
         if (x < AVG_LOW)
            return AVG_LOW;
         return x;
      endfunction

      function logic [AGE_BITS-1:0] age_step(logic [AGE_BITS-1:0] a);
         return (a == AGE_MAX) ? a : a + 1'b1;
      endfunction

      // Advance the statistics by one accepted sample and queue the result
      function void accept_sample(sample_type s);
         longint s_w;
         longint s_q;
         longint weight;
         longint prod;
         stats_type r;
         s_w   = s;
         s_q   = clamp32(s_w * 65536);
         count = count + 1'b1;
         if (!seeded) begin
            seeded   = 1'b1;
            avg      = s_q;
            lowest   = s_w;
            highest  = s_w;
            low_age  = AGE_BITS'(1);
            high_age = AGE_BITS'(1);
         end else begin
            // alpha above one acts as one
            weight = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
            prod   = weight * (s_q - avg);
            // round to nearest, ties towards plus infinity
            avg    = clamp32(avg + ((prod + 32768) >>> 16));
            if (highest < s_w) begin
               high_age = '0;
               highest  = s_w;
            end
            if (lowest > s_w) begin
               low_age = '0;
               lowest  = s_w;
            end
            // expiry compares the age before this sample's increment
            if (low_age == limit) begin
               lowest  = s_w;
               low_age = '0;
            end
            if (high_age == limit) begin
               highest  = s_w;
               high_age = '0;
            end
            low_age  = age_step(low_age);
            high_age = age_step(high_age);
         end
         r.sample_number = count;
         r.value         = s;
         r.minimum       = sample_type'(lowest);
         r.average       = AVG_BITS'(avg);
         r.maximum       = sample_type'(highest);
         expected_stats.push_back(r);
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(stats_type got);
         stats_type want;
         if (expected_stats.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, sample_number %0d with nothing pending",
                     $time, got.sample_number);
            return;
         end
         want = expected_stats.pop_front();
         compare_field("sample_number", want.sample_number, got.sample_number);
         compare_field("value", want.value, got.value);
         compare_field("minimum", want.minimum, got.minimum);
         compare_field("average", want.average, got.average);
         compare_field("maximum", want.maximum, got.maximum);
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   sample_type                 req_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [COUNT_BITS-1:0]      rsp_sample_number;
   sample_type                 rsp_value;
   sample_type                 rsp_minimum;
   logic signed [AVG_BITS-1:0] rsp_average;
   sample_type                 rsp_maximum;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_data;

   ewma_with_expiring_min_max #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_number(rsp_sample_number),
      .rsp_value        (rsp_value),
      .rsp_minimum      (rsp_minimum),
      .rsp_average      (rsp_average),
      .rsp_maximum      (rsp_maximum),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   ewma_stats_board board;
   stats_type       seen_result;
   int              cycles      = 0;
   int              gap_odds    = 0;   // 1-in-N chance of a sender gap, 0 for none
   int              stall_odds  = 0;   // 1-in-N chance of a receiver stall burst
   int              stall_left  = 0;
   int              hold_cycles = 0;   // long hold-off requested from the receiver
   int              drift       = 0;

   // directed samples: extremes, alternating bits, then a flat run to expire the maximum
   sample_type opening_run[12] = '{0, SAMPLE_MAX, SAMPLE_MIN, -1, 1, ALT_ONES, ~ALT_ONES,
                                   7, 7, 7, 7, 7};
   sample_type over_one_run[4] = '{100, -100, SAMPLE_MAX, SAMPLE_MIN};
   sample_type zero_alpha_run[3] = '{5, -5, 9};
   sample_type full_alpha_run[3] = '{1234, SAMPLE_MIN, SAMPLE_MAX};

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result monitor: check each result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_result.sample_number = rsp_sample_number;
         seen_result.value         = rsp_value;
         seen_result.minimum       = rsp_minimum;
         seen_result.average       = rsp_average;
         seen_result.maximum       = rsp_maximum;
         board.check_result(seen_result);
      end
   end

   // receiver: random stall bursts plus the occasional long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (hold_cycles > 0) begin
            stall_left  = hold_cycles - 1;
            hold_cycles = 0;
            rsp_stall <= 1'b1;
         end else if (stall_odds > 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
            stall_left = $urandom_range(19, 1) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // mostly a slowly wandering level with noise, so extremes age and expire
   function automatic sample_type pick_sample();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 20)
         return sample_type'($urandom);
      if (roll < 30) begin
         case ($urandom_range(3, 0))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      drift = drift + int'($urandom_range(600, 0)) - 300;
      if (drift > 30000)
         drift = 30000;
      if (drift < -30000)
         drift = -30000;
      return sample_type'(drift + int'($urandom_range(100, 0)) - 50);
   endfunction

   task automatic pause_sender(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_sample <= sample_type'($urandom);
      end
   endtask

   task automatic offer_sample(sample_type s);
      @(negedge clock);
      req_valid <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      board.accept_sample(s);
   endtask

   task automatic feed(sample_type s);
      if (gap_odds > 0 && $urandom_range(gap_odds - 1, 0) == 0)
         pause_sender($urandom_range(19, 1));
      offer_sample(s);
   endtask

   // wait for every owed result, then let the pipeline settle
   task automatic drain();
      pause_sender(1);
      while (board.expected_stats.size() != 0)
         @(posedge clock);
      pause_sender(4);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_register(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(logic [ALPHA_BITS-1:0] alpha, logic [LIMIT_BITS-1:0] limit);
      drain();
      write_register(CSR_ALPHA, alpha);
      write_register(CSR_LIMIT, limit);
   endtask

   initial begin
      int phase;
      logic [ALPHA_BITS-1:0] alpha_pick;
      logic [LIMIT_BITS-1:0] limit_pick;
      board      = new();
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_sample = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_ALPHA;
      csr_data   = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, first sample seeds everything
      foreach (opening_run[i])
         offer_sample(opening_run[i]);
      // alpha above one, limit of zero
      set_config('1, 0);
      foreach (over_one_run[i])
         offer_sample(over_one_run[i]);
      // alpha zero freezes the average, limit one
      set_config(0, 1);
      foreach (zero_alpha_run[i])
         offer_sample(zero_alpha_run[i]);
      // alpha exactly one, largest limit
      set_config(ALPHA_ONE, '1);
      foreach (full_alpha_run[i])
         offer_sample(full_alpha_run[i]);

      // random phases with idling on both sides
      for (phase = 0; phase < IDLE_PHASES; phase++) begin
         case (phase)
            0: begin
               alpha_pick = ALPHA_BITS'($urandom_range(ALPHA_ONE, 0));
               limit_pick = LIMIT_BITS'($urandom_range(8, 2));
               gap_odds   = 4;
               stall_odds = 4;
            end
            1: begin
               alpha_pick = 0;
               limit_pick = 1;
               gap_odds   = 0;
               stall_odds = 0;
            end
            2: begin
               alpha_pick = ALPHA_ONE;
               limit_pick = '1;
               gap_odds   = 3;
               stall_odds = 6;
            end
            3: begin
               alpha_pick = ALPHA_BITS'($urandom);
               limit_pick = 0;
               gap_odds   = 8;
               stall_odds = 2;
            end
            4: begin
               alpha_pick = 1;
               limit_pick = LIMIT_BITS'($urandom_range(20, 1));
               gap_odds   = 2;
               stall_odds = 2;
            end
            default: begin
               alpha_pick = ALPHA_BITS'($urandom_range(ALPHA_ONE, 0));
               limit_pick = LIMIT_BITS'($urandom_range(65535, 1));
               gap_odds   = 5;
               stall_odds = 0;
            end
         endcase
         set_config(alpha_pick, limit_pick);
         // long receiver hold-off while samples keep coming back to back
         if (phase == 3)
            hold_cycles = 120;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 3 && i < 30)
               offer_sample(pick_sample());
            else
               feed(pick_sample());
         end
      end

      // no idling from here on
      gap_odds   = 0;
      stall_odds = 0;

      // pin the extremes with expiry off, then let the largest limit apply
      alpha_pick = ALPHA_BITS'($urandom_range(ALPHA_ONE, 0));
      set_config(alpha_pick, 0);
      offer_sample(SAMPLE_MAX);
      offer_sample(SAMPLE_MIN);
      repeat (PIN_RUN)
         offer_sample(sample_type'($urandom));
      set_config(alpha_pick, '1);
      repeat (20)
         offer_sample(pick_sample());

      set_config(ALPHA_BITS'($urandom_range(ALPHA_ONE, 0)), 3);
      repeat (TAIL_ITEMS)
         offer_sample(pick_sample());

      drain();
      repeat (8) @(posedge clock);
      if (board.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
design/emm_pkg.sv
design/emm_average.sv
design/emm_extremes.sv
design/ewma_with_expiring_min_max.sv
tb/ewma_with_expiring_min_max_tb.sv
